// File: rtl/core/masked_box_mean_smoother_defines.svh
// ----------------------------------------------------------------------------
// masked_box_mean_smoother_defines
// assertion macros shared by the smoother rtl
// ----------------------------------------------------------------------------
`ifndef MASKED_BOX_MEAN_SMOOTHER_DEFINES_SVH
`define MASKED_BOX_MEAN_SMOOTHER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MBMS_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mbms same-cycle check failed");

// next-cycle implication, checked out of reset
`define MBMS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mbms next-cycle check failed");

`endif

// File: rtl/core/mbms_pkg.sv
// ----------------------------------------------------------------------------
// mbms_pkg
// shared constants and types of the masked box mean smoother
// ----------------------------------------------------------------------------
package mbms_pkg;

  localparam int MAX_COLUMNS  = 4096;
  localparam int SAMPLE_WIDTH = 32;
  localparam int RING_ROWS    = 5;
  localparam int RING_COLS    = MAX_COLUMNS + 2;
  localparam int COL_W        = $clog2(RING_COLS);
  localparam int SLOT_W       = $clog2(RING_ROWS);
  localparam int ROW_W        = 17;
  localparam int CSUM_W       = SAMPLE_WIDTH + 3;
  localparam int SUM_W        = SAMPLE_WIDTH + 5;
  localparam int MAG_W        = SUM_W - 1;
  localparam int CNT_W        = 5;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS = 2'd2;

  // one stored sample
  typedef struct packed {
    logic                           undef;
    logic signed [SAMPLE_WIDTH-1:0] value;
  } entry_t;

  // one column of the ring, all row slots
  typedef entry_t [RING_ROWS-1:0] column_t;

  // divider control
  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

endpackage

// File: rtl/core/mbms_line_store.sv
// ----------------------------------------------------------------------------
// mbms_line_store
// five-row ring of samples, one lane written, whole column read
// ----------------------------------------------------------------------------
module mbms_line_store (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [mbms_pkg::SLOT_W-1:0] wslot_i,
  input  logic [mbms_pkg::COL_W-1:0]  waddr_i,
  input  mbms_pkg::entry_t          wdata_i,
  input  logic [mbms_pkg::COL_W-1:0]  raddr_i,
  output mbms_pkg::column_t         rdata_o
);
  import mbms_pkg::*;

  entry_t  mem_q [RING_ROWS][RING_COLS];
  column_t rdata_q;

  // write one row lane
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wslot_i][waddr_i] <= wdata_i;
    end
  end

  // registered column read
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < RING_ROWS; s++) begin
      rdata_q[s] <= mem_q[s][raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/mbms_divider.sv
// ----------------------------------------------------------------------------
// mbms_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mbms_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mbms_pkg::div_req_t         req_i,
  output logic                       done_o,
  output logic [mbms_pkg::MAG_W-1:0] quotient_o
);
  import mbms_pkg::*;

  localparam int STEP_W = $clog2(MAG_W);

  logic [MAG_W-1:0]  sh_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W-1:0]  dvs_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q;
  logic              done_q;
  logic [CNT_W:0]    rem_shift;
  logic              qbit;

  // trial subtract
  assign rem_shift = {rem_q, sh_q[MAG_W-1]};
  assign qbit      = (rem_shift >= {1'b0, dvs_q});

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(MAG_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sh_q  <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      sh_q  <= {sh_q[MAG_W-2:0], qbit};
      rem_q <= qbit ? CNT_W'(rem_shift - {1'b0, dvs_q}) : rem_shift[CNT_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = sh_q;

endmodule

// File: rtl/core/masked_box_mean_smoother.sv
// ----------------------------------------------------------------------------
// masked_box_mean_smoother
// masked 3x3 / 5x5 box mean over a raster height grid
// ----------------------------------------------------------------------------
// usage
//   in channel: one sample per transaction in raster order, each row padded
//   with R columns and the grid with R rows (R = window radius)
//   out channel: one mean per grid position, flagged undefined when no
//   defined sample lies in the window, last_of_grid on the final position
//   config: write grid_columns, grid_rows or window_radius while idle; a
//   write to one of these restarts the grid at stream position (0, 0)
//   sequence: a padding-phase sample is taken and leaves the block idle; a
//   sample that closes a window stalls the input through 2R + 1 column
//   reads from the line store, one accumulate, one setup, the bit-serial
//   divider and one load, then the idle state takes the next sample; a
//   window with no defined sample skips the divider
//   reset: counters clear, registers return to 4096 columns, 1 row, radius 1
//   stall: a stalled result holds in the output register; the next sample
//   is still taken and its work runs until it needs the output register
// ----------------------------------------------------------------------------
`include "masked_box_mean_smoother_defines.svh"

module masked_box_mean_smoother (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [mbms_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [mbms_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [mbms_pkg::SAMPLE_WIDTH-1:0] height_sample_i,
  input  logic                                   sample_undefined_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [mbms_pkg::SAMPLE_WIDTH-1:0] smoothed_height_o,
  output logic                                   result_undefined_o,
  output logic                                   last_of_grid_o
);
  import mbms_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_LAST = 3'd2;
  localparam logic [2:0] ST_MEAN = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  // config and counters
  logic [12:0]       cols_q;
  logic [15:0]       rows_q;
  logic [1:0]        rad_q;
  logic [ROW_W-1:0]  p_q;
  logic [COL_W-1:0]  q_q;
  logic [SLOT_W-1:0] slot_q;

  // sequencer
  logic [2:0]          state_q;
  logic [RING_ROWS-1:0] row_mask_q;
  logic signed [COL_W:0] cbase_q;
  logic [2:0]          j_q;
  logic                last_q;
  logic                rd_pend_q;
  logic                rd_cv_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                neg_q;

  // output register
  logic                         out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] res_q;
  logic                         undef_q;
  logic                         olast_q;
  logic signed [SAMPLE_WIDTH-1:0] pend_res_q;
  logic                         pend_undef_q;

  logic [12:0]       eff_cols;
  logic [15:0]       eff_rows;
  logic [1:0]        eff_rad;
  logic              in_acc;
  logic              produce;
  logic              is_last;
  logic [RING_ROWS-1:0] row_mask_d;
  logic [COL_W:0]    q_wrap_lhs;
  logic [COL_W:0]    q_wrap_rhs;
  logic [ROW_W:0]    p_wrap_rhs;
  logic signed [COL_W:0] col_s;
  logic              cv;
  logic [COL_W-1:0]  raddr;
  column_t           rdata;
  entry_t            wdata;
  logic signed [CSUM_W-1:0] csum;
  logic [2:0]        ccnt;
  logic [SUM_W-1:0]  mag_full;
  div_req_t          div_req;
  logic              div_done;
  logic [MAG_W-1:0]  quotient;
  logic              out_free;

  // effective config
  always_comb begin
    if (cols_q == 13'd0) begin
      eff_cols = 13'd1;
    end else if (cols_q > 13'(MAX_COLUMNS)) begin
      eff_cols = 13'(MAX_COLUMNS);
    end else begin
      eff_cols = cols_q;
    end
    eff_rows = (rows_q == 16'd0) ? 16'd1 : rows_q;
    case (rad_q)
      2'd0:    eff_rad = 2'd1;
      2'd3:    eff_rad = 2'd2;
      default: eff_rad = rad_q;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign produce    = (p_q >= ROW_W'(eff_rad)) && (q_q >= COL_W'(eff_rad));

  // stream wrap points and last position
  assign q_wrap_lhs = {1'b0, q_q} + 1'b1;
  assign q_wrap_rhs = {1'b0, eff_cols} + {12'd0, eff_rad};
  assign p_wrap_rhs = {2'b0, eff_rows} + {16'd0, eff_rad};
  assign is_last = ({1'b0, p_q} == p_wrap_rhs - 1'b1)
                && ({1'b0, q_q} == q_wrap_rhs - 1'b1);

  // row slots that fall inside the grid
  always_comb begin
    logic [3:0] sl;
    row_mask_d = '0;
    for (int k = 0; k < RING_ROWS; k++) begin
      sl = {1'b0, slot_q} + 4'(RING_ROWS - k);
      if (sl >= 4'(RING_ROWS)) begin
        sl = sl - 4'(RING_ROWS);
      end
      if ((k <= 2 * int'(eff_rad)) && (p_q >= ROW_W'(k))
          && ((p_q - ROW_W'(k)) < {1'b0, eff_rows})) begin
        row_mask_d[sl[SLOT_W-1:0]] = 1'b1;
      end
    end
  end

  // column address for the current read
  assign col_s = cbase_q + $signed({11'd0, j_q});
  assign cv    = !col_s[COL_W] && (col_s[COL_W-1:0] < eff_cols);
  assign raddr = cv ? col_s[COL_W-1:0] : '0;

  assign wdata.undef = sample_undefined_i;
  assign wdata.value = height_sample_i;

  mbms_line_store u_store (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .wslot_i (slot_q),
    .waddr_i (q_q),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // sum of the defined samples in one column
  always_comb begin
    csum = '0;
    ccnt = '0;
    for (int s = 0; s < RING_ROWS; s++) begin
      if (row_mask_q[s] && rd_cv_q && !rdata[s].undef) begin
        csum = csum + CSUM_W'(rdata[s].value);
        ccnt = ccnt + 3'd1;
      end
    end
  end

  // divider request, round half away from zero on the magnitude
  assign mag_full         = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign div_req.start    = (state_q == ST_MEAN) && (cnt_q != '0);
  assign div_req.dividend = mag_full[MAG_W-1:0] + {{(MAG_W-CNT_W+1){1'b0}}, cnt_q[CNT_W-1:1]};
  assign div_req.divisor  = cnt_q;

  mbms_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  // config, counters and sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q    <= 13'(MAX_COLUMNS);
      rows_q    <= 16'd1;
      rad_q     <= 2'd1;
      p_q       <= '0;
      q_q       <= '0;
      slot_q    <= '0;
      state_q   <= ST_IDLE;
      rd_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_pend_q <= (state_q == ST_READ);
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_GRID_COLUMNS:  cols_q <= cfg_data_i[12:0];
          REG_GRID_ROWS:     rows_q <= cfg_data_i;
          REG_WINDOW_RADIUS: rad_q  <= cfg_data_i[1:0];
          default: ;
        endcase
        if (cfg_index_i == REG_GRID_COLUMNS || cfg_index_i == REG_GRID_ROWS
            || cfg_index_i == REG_WINDOW_RADIUS) begin
          p_q    <= '0;
          q_q    <= '0;
          slot_q <= '0;
        end
      end else if (in_acc) begin
        if (q_wrap_lhs >= q_wrap_rhs) begin
          q_q <= '0;
          if ({1'b0, p_q} + 1'b1 >= p_wrap_rhs) begin
            p_q    <= '0;
            slot_q <= '0;
          end else begin
            p_q    <= p_q + 1'b1;
            slot_q <= (slot_q == SLOT_W'(RING_ROWS - 1)) ? '0 : slot_q + 1'b1;
          end
        end else begin
          q_q <= q_q + 1'b1;
        end
      end
      case (state_q)
        ST_IDLE: if (in_acc && produce) state_q <= ST_READ;
        ST_READ: if (j_q == {eff_rad, 1'b0}) state_q <= ST_LAST;
        ST_LAST: state_q <= ST_MEAN;
        ST_MEAN: state_q <= (cnt_q == '0) ? ST_OUT : ST_DIV;
        ST_DIV:  if (div_done) state_q <= ST_OUT;
        ST_OUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // window datapath
  always_ff @(posedge clk_i) begin
    rd_cv_q <= cv;
    if (in_acc) begin
      row_mask_q <= row_mask_d;
      cbase_q    <= $signed({1'b0, q_q}) - $signed({11'd0, eff_rad, 1'b0});
      j_q        <= '0;
      last_q     <= is_last;
      sum_q      <= '0;
      cnt_q      <= '0;
    end else begin
      if (state_q == ST_READ) begin
        j_q <= j_q + 1'b1;
      end
      if (rd_pend_q) begin
        sum_q <= sum_q + SUM_W'(csum);
        cnt_q <= cnt_q + CNT_W'(ccnt);
      end
    end
    if (state_q == ST_MEAN) begin
      neg_q        <= sum_q[SUM_W-1];
      pend_res_q   <= '0;
      pend_undef_q <= (cnt_q == '0);
    end
    if (state_q == ST_DIV && div_done) begin
      pend_res_q <= neg_q ? -$signed(quotient[SAMPLE_WIDTH-1:0])
                          : $signed(quotient[SAMPLE_WIDTH-1:0]);
    end
    if (state_q == ST_OUT && out_free) begin
      res_q   <= pend_res_q;
      undef_q <= pend_undef_q;
      olast_q <= last_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign smoothed_height_o  = res_q;
  assign result_undefined_o = undef_q;
  assign last_of_grid_o     = olast_q;

  // checks
  `MBMS_ASSERT_IMPLY(a_undef_zero, clk_i, rst_ni, out_valid_o && result_undefined_o, smoothed_height_o == '0)
  `MBMS_ASSERT_IMPLY(a_cnt_bound, clk_i, rst_ni, state_q == ST_MEAN, cnt_q <= CNT_W'(25))
  `MBMS_ASSERT_NEXT(a_div_nonzero, clk_i, rst_ni, state_q == ST_MEAN && cnt_q == '0, state_q == ST_OUT)

endmodule
